[rtl/gdrc_pkg.sv]
// ----------------------------------------------------------------------------
// gdrc_pkg
// Types, constants and the arctangent table of the grid ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

package gdrc_pkg;

  localparam int CELL_W       = 6;
  localparam int POS_W        = 22;
  localparam int FRAC_W       = 16;
  localparam int ANG_W        = 16;
  localparam int DIST_W       = 24;
  localparam int CS_W         = 19;
  localparam int MUL_W        = 17;
  localparam int Z_W          = 17;
  localparam int CORDIC_ITERS = 15;
  localparam int CORDIC_GAIN  = 39797;
  localparam int IN_DW        = 96;
  localparam int OUT_DW       = 40;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [ANG_W-1:0] angle;
  } cs_ctrl_t;

  // Arctangent of 2^-i in units of 1/65536 turn.
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [3:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = 17'sd8192;
      4'd1:    v = 17'sd4836;
      4'd2:    v = 17'sd2555;
      4'd3:    v = 17'sd1297;
      4'd4:    v = 17'sd651;
      4'd5:    v = 17'sd326;
      4'd6:    v = 17'sd163;
      4'd7:    v = 17'sd81;
      4'd8:    v = 17'sd41;
      4'd9:    v = 17'sd20;
      4'd10:   v = 17'sd10;
      4'd11:   v = 17'sd5;
      4'd12:   v = 17'sd3;
      4'd13:   v = 17'sd1;
      4'd14:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/gdrc_cordic.sv]
// ----------------------------------------------------------------------------
// gdrc_cordic
// Iterative CORDIC rotation giving cosine and sine of a 16-bit turn angle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdrc_cordic import gdrc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cs_ctrl_t               ctrl_i,
  output logic                        done_o,
  output logic signed [CS_W-1:0]      cos_o,
  output logic signed [CS_W-1:0]      sin_o
);

  logic signed [CS_W-1:0] x_q, y_q, x_sh, y_sh;
  logic signed [Z_W-1:0]  z_q, z_in;
  logic [3:0]             i_q;
  logic                   busy_q, done_q, flip_q, flip_in;

  // Fold the angle into a half turn around zero; the fold negates both results.
  always_comb begin
    z_in    = $signed({ctrl_i.angle[ANG_W-1], ctrl_i.angle});
    flip_in = 1'b0;
    if (z_in > 17'sd16384) begin
      z_in    = z_in - 17'sd32768;
      flip_in = 1'b1;
    end else if (z_in < -17'sd16384) begin
      z_in    = z_in + 17'sd32768;
      flip_in = 1'b1;
    end
  end

  assign x_sh = x_q >>> i_q;
  assign y_sh = y_q >>> i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      i_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        x_q    <= CS_W'(CORDIC_GAIN);
        y_q    <= '0;
        z_q    <= z_in;
        i_q    <= '0;
        flip_q <= flip_in;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (z_q >= 0) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - atan_turn(i_q);
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + atan_turn(i_q);
        end
        i_q <= i_q + 4'd1;
        if (i_q == 4'(CORDIC_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

`default_nettype wire

[rtl/gdrc_muldiv.sv]
// ----------------------------------------------------------------------------
// gdrc_muldiv
// Shared bit-serial unit: shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module gdrc_muldiv import gdrc_pkg::*; #(
  parameter int DW = 39
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire md_ctrl_t              ctrl_i,
  input  wire logic [DW-1:0]         a_i,
  input  wire logic [MUL_W-1:0]      b_i,
  output logic                       done_o,
  output logic [DW+MUL_W-1:0]        res_o
);

  localparam int PW    = DW + MUL_W;
  localparam int CNT_W = $clog2(DW);

  logic [PW-1:0]    acc_q, opa_q;
  logic [MUL_W-1:0] opb_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  md_op_e           op_q;
  logic [MUL_W:0]   trial, diff;
  logic             qbit, last;

  always_comb begin
    trial = {rem_q, opa_q[DW-1]};
    diff  = trial - {1'b0, opb_q};
    qbit  = (trial >= {1'b0, opb_q});
    if (op_q == MD_MUL) begin
      last = (cnt_q == CNT_W'(MUL_W - 1));
    end else begin
      last = (cnt_q == CNT_W'(DW - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      opa_q  <= '0;
      opb_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        op_q   <= ctrl_i.op;
        acc_q  <= '0;
        opa_q  <= PW'(a_i);
        opb_q  <= b_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (op_q == MD_MUL) begin
          if (opb_q[0]) begin
            acc_q <= acc_q + opa_q;
          end
          opb_q <= opb_q >> 1;
        end else begin
          rem_q <= qbit ? diff[MUL_W-1:0] : trial[MUL_W-1:0];
          acc_q <= {acc_q[PW-2:0], qbit};
        end
        opa_q <= opa_q << 1;
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

`default_nettype wire

[rtl/grid_dda_ray_caster_core.sv]
// Sequence: a write word is stored in the map as it is accepted. A cast runs the CORDIC up to
// twice, up to three divisions and three multiplies, passes ST_STEP, ST_CHECK and ST_TEST for
// each grid step (steps <= W + H + 2) and loads the result word in ST_OUT.
// Throughput: one item at a time; a finished result waits in the output register, and a new
// cast finishes only after the previous result word has been taken.
// Reset: a clearing pass in ST_CLEAR marks every cell wall before the first item is accepted.
// ----------------------------------------------------------------------------
// grid_dda_ray_caster_core
// Wall map, sequencer and DDA grid walk of the ray caster.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_dda_ray_caster_core import gdrc_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  // cell_x, cell_y, cell_is_wall, pos_x, pos_y, ray_angle, view_angle
  input  wire logic [IN_DW-1:0]  s_tdata_i,
  // func
  input  wire logic              s_tuser_i,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  // hit_x, hit_y, hit_side, perp_distance
  output logic [OUT_DW-1:0]      m_tdata_o
);

  localparam int MAXD     = (MAP_WIDTH > MAP_HEIGHT)
                            ? ((MAP_WIDTH > 64) ? MAP_WIDTH : 64)
                            : ((MAP_HEIGHT > 64) ? MAP_HEIGHT : 64);
  localparam int NUM_W    = $clog2(MAXD) + 17;
  localparam int DW       = (NUM_W + 16 > 33) ? NUM_W + 16 : 33;
  localparam int PW       = DW + MUL_W;
  localparam int SIDE_W   = 50 + $clog2(MAP_WIDTH + MAP_HEIGHT + 3);
  localparam int MX_W     = $clog2(((MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT) + 1) + 1;
  localparam int DEPTH    = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int STEP_LIM = MAP_WIDTH + MAP_HEIGHT + 2;
  localparam int STEP_W   = $clog2(STEP_LIM + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CS1, ST_DIVX, ST_DIVY, ST_MULX, ST_MULY,
    ST_STEP, ST_CHECK, ST_TEST, ST_DIVE, ST_CS2, ST_MULP, ST_OUT
  } st_e;

  st_e state_q;

  // Input word fields.
  logic              in_func, in_wall;
  logic [CELL_W-1:0] in_cx, in_cy;
  logic [POS_W-1:0]  in_px, in_py;
  logic [ANG_W-1:0]  in_ray, in_view;

  assign in_func = s_tuser_i;
  assign in_cx   = s_tdata_i[5:0];
  assign in_cy   = s_tdata_i[11:6];
  assign in_wall = s_tdata_i[12];
  assign in_px   = s_tdata_i[34:13];
  assign in_py   = s_tdata_i[56:35];
  assign in_ray  = s_tdata_i[72:57];
  assign in_view = s_tdata_i[88:73];

  logic accept;
  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  // Shared units.
  cs_ctrl_t               cs_ctrl_q;
  logic                   cs_done;
  logic signed [CS_W-1:0] cs_cos, cs_sin;
  md_ctrl_t               md_ctrl_q;
  logic [DW-1:0]          md_a_q;
  logic [MUL_W-1:0]       md_b_q;
  logic                   md_done;
  logic [PW-1:0]          md_res;

  gdrc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cs_ctrl_q),
    .done_o (cs_done),
    .cos_o  (cs_cos),
    .sin_o  (cs_sin)
  );

  gdrc_muldiv #(.DW(DW)) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (md_ctrl_q),
    .a_i    (md_a_q),
    .b_i    (md_b_q),
    .done_o (md_done),
    .res_o  (md_res)
  );

  // Ray state.
  logic [POS_W-1:0]        px_q, py_q;
  logic [ANG_W-1:0]        ray_q, view_q;
  logic                    inf_x_q, inf_y_q, sx_neg_q, sy_neg_q, side_q;
  logic [MUL_W-1:0]        magc_q, mags_q;
  logic [32:0]             dx_q, dy_q;
  logic [SIDE_W-1:0]       side_x_q, side_y_q;
  logic signed [MX_W-1:0]  mx_q, my_q;
  logic [STEP_W-1:0]       stepn_q;
  logic [DW-1:0]           eu_q;
  logic [DIST_W-1:0]       perp_q;
  logic [ADDR_W-1:0]       clr_q;
  logic                    rd_q;
  logic                    m_valid_q;
  logic [OUT_DW-1:0]       m_data_q;

  // Map memory port.
  logic                    mem [DEPTH];
  logic                    mem_we, mem_wdata;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b1;
    mem_waddr = clr_q;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && !in_func && (32'(in_cx) < MAP_WIDTH)
                 && (32'(in_cy) < MAP_HEIGHT)) begin
      mem_we    = 1'b1;
      mem_wdata = in_wall;
      mem_waddr = ADDR_W'(32'(in_cy) * MAP_WIDTH + 32'(in_cx));
    end
    mem_raddr = ADDR_W'(32'($unsigned(my_q)) * MAP_WIDTH + 32'($unsigned(mx_q)));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_CHECK) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Combinational helpers.
  logic [CS_W-1:0]   abs_cos, abs_sin;
  logic [MUL_W-1:0]  fx_span, fy_span;
  logic              take_x, out_of_map;
  logic [NUM_W-1:0]  bnd, posn, num;
  logic [MX_W-1:0]   coord;
  logic              start_out;

  always_comb begin
    abs_cos = cs_cos[CS_W-1] ? CS_W'(-cs_cos) : CS_W'(cs_cos);
    abs_sin = cs_sin[CS_W-1] ? CS_W'(-cs_sin) : CS_W'(cs_sin);
    fx_span = sx_neg_q ? {1'b0, px_q[FRAC_W-1:0]} : 17'h10000 - {1'b0, px_q[FRAC_W-1:0]};
    fy_span = sy_neg_q ? {1'b0, py_q[FRAC_W-1:0]} : 17'h10000 - {1'b0, py_q[FRAC_W-1:0]};
    // Ties step the y axis.
    take_x  = !inf_x_q && (inf_y_q || (side_x_q < side_y_q));
    out_of_map = mx_q[MX_W-1] || my_q[MX_W-1] || (mx_q >= MAP_WIDTH)
                 || (my_q >= MAP_HEIGHT);
    start_out  = (32'(in_px[POS_W-1:FRAC_W]) >= MAP_WIDTH)
                 || (32'(in_py[POS_W-1:FRAC_W]) >= MAP_HEIGHT);
    // Distance from the start to the crossed grid line on the last axis.
    coord = side_q ? my_q : mx_q;
    bnd   = (NUM_W'($unsigned(coord)) << FRAC_W)
            + ((side_q ? sy_neg_q : sx_neg_q) ? NUM_W'(65536) : NUM_W'(0));
    posn  = side_q ? NUM_W'(py_q) : NUM_W'(px_q);
    num   = (bnd >= posn) ? bnd - posn : posn - bnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cs_ctrl_q <= '0;
      md_ctrl_q <= '0;
      md_a_q    <= '0;
      md_b_q    <= '0;
      px_q      <= '0;
      py_q      <= '0;
      ray_q     <= '0;
      view_q    <= '0;
      inf_x_q   <= 1'b0;
      inf_y_q   <= 1'b0;
      sx_neg_q  <= 1'b0;
      sy_neg_q  <= 1'b0;
      side_q    <= 1'b0;
      magc_q    <= '0;
      mags_q    <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      side_x_q  <= '0;
      side_y_q  <= '0;
      mx_q      <= '0;
      my_q      <= '0;
      stepn_q   <= '0;
      eu_q      <= '0;
      perp_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      cs_ctrl_q.start <= 1'b0;
      md_ctrl_q.start <= 1'b0;
      if (m_valid_q && m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && in_func && !start_out) begin
            px_q      <= in_px;
            py_q      <= in_py;
            ray_q     <= in_ray;
            view_q    <= in_view;
            mx_q      <= MX_W'(in_px[POS_W-1:FRAC_W]);
            my_q      <= MX_W'(in_py[POS_W-1:FRAC_W]);
            stepn_q   <= '0;
            cs_ctrl_q <= '{start: 1'b1, angle: in_ray};
            state_q   <= ST_CS1;
          end
        end
        ST_CS1: begin
          if (cs_done) begin
            inf_x_q  <= (cs_cos == '0);
            inf_y_q  <= (cs_sin == '0);
            sx_neg_q <= cs_cos[CS_W-1];
            sy_neg_q <= cs_sin[CS_W-1];
            magc_q   <= abs_cos[MUL_W-1:0];
            mags_q   <= abs_sin[MUL_W-1:0];
            dx_q     <= '0;
            dy_q     <= '0;
            md_a_q   <= DW'(33'h1_0000_0000);
            if (cs_cos == '0 && cs_sin == '0) begin
              state_q <= ST_IDLE;
            end else if (cs_cos != '0) begin
              md_b_q    <= abs_cos[MUL_W-1:0];
              md_ctrl_q <= '{start: 1'b1, op: MD_DIV};
              state_q   <= ST_DIVX;
            end else begin
              md_b_q    <= abs_sin[MUL_W-1:0];
              md_ctrl_q <= '{start: 1'b1, op: MD_DIV};
              state_q   <= ST_DIVY;
            end
          end
        end
        ST_DIVX: begin
          if (md_done) begin
            dx_q <= md_res[32:0];
            if (!inf_y_q) begin
              md_a_q    <= DW'(33'h1_0000_0000);
              md_b_q    <= mags_q;
              md_ctrl_q <= '{start: 1'b1, op: MD_DIV};
              state_q   <= ST_DIVY;
            end else begin
              md_a_q    <= DW'(md_res[32:0]);
              md_b_q    <= fx_span;
              md_ctrl_q <= '{start: 1'b1, op: MD_MUL};
              state_q   <= ST_MULX;
            end
          end
        end
        ST_DIVY: begin
          if (md_done) begin
            dy_q      <= md_res[32:0];
            md_ctrl_q <= '{start: 1'b1, op: MD_MUL};
            if (!inf_x_q) begin
              md_a_q  <= DW'(dx_q);
              md_b_q  <= fx_span;
              state_q <= ST_MULX;
            end else begin
              md_a_q  <= DW'(md_res[32:0]);
              md_b_q  <= fy_span;
              state_q <= ST_MULY;
            end
          end
        end
        ST_MULX: begin
          if (md_done) begin
            side_x_q <= SIDE_W'(md_res);
            if (!inf_y_q) begin
              md_a_q    <= DW'(dy_q);
              md_b_q    <= fy_span;
              md_ctrl_q <= '{start: 1'b1, op: MD_MUL};
              state_q   <= ST_MULY;
            end else begin
              state_q <= ST_STEP;
            end
          end
        end
        ST_MULY: begin
          if (md_done) begin
            side_y_q <= SIDE_W'(md_res);
            state_q  <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (take_x) begin
            side_x_q <= side_x_q + (SIDE_W'(dx_q) << FRAC_W);
            mx_q     <= sx_neg_q ? mx_q - MX_W'(1) : mx_q + MX_W'(1);
            side_q   <= 1'b0;
          end else begin
            side_y_q <= side_y_q + (SIDE_W'(dy_q) << FRAC_W);
            my_q     <= sy_neg_q ? my_q - MX_W'(1) : my_q + MX_W'(1);
            side_q   <= 1'b1;
          end
          stepn_q <= stepn_q + STEP_W'(1);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          state_q <= out_of_map ? ST_IDLE : ST_TEST;
        end
        ST_TEST: begin
          if (rd_q) begin
            md_a_q    <= DW'({num, 16'h0000});
            md_b_q    <= side_q ? mags_q : magc_q;
            md_ctrl_q <= '{start: 1'b1, op: MD_DIV};
            state_q   <= ST_DIVE;
          end else if (stepn_q == STEP_W'(STEP_LIM)) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_STEP;
          end
        end
        ST_DIVE: begin
          if (md_done) begin
            eu_q      <= md_res[DW-1:0];
            cs_ctrl_q <= '{start: 1'b1, angle: ray_q - view_q};
            state_q   <= ST_CS2;
          end
        end
        ST_CS2: begin
          if (cs_done) begin
            if (cs_cos[CS_W-1] || cs_cos == '0) begin
              perp_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              md_a_q    <= eu_q;
              md_b_q    <= cs_cos[MUL_W-1:0];
              md_ctrl_q <= '{start: 1'b1, op: MD_MUL};
              state_q   <= ST_MULP;
            end
          end
        end
        ST_MULP: begin
          if (md_done) begin
            if (|md_res[PW-1:FRAC_W+DIST_W]) begin
              perp_q <= '1;
            end else begin
              perp_q <= md_res[FRAC_W+DIST_W-1:FRAC_W];
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // The previous word may still be waiting, so the register is loaded only here.
          if (!m_valid_q || m_tready_i) begin
            m_data_q[5:0]   <= mx_q[CELL_W-1:0];
            m_data_q[11:6]  <= my_q[CELL_W-1:0];
            m_data_q[12]    <= side_q;
            m_data_q[36:13] <= perp_q;
            m_data_q[39:37] <= '0;
            m_valid_q       <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cs_ctrl_q.start && md_ctrl_q.start))
    else $error("CORDIC and multiply/divide started together");

  a_read_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST) |-> (!mx_q[MX_W-1] && !my_q[MX_W-1]
      && (mx_q < MAP_WIDTH) && (my_q < MAP_HEIGHT)))
    else $error("map read outside the grid");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stepn_q) <= STEP_LIM)
    else $error("grid walk ran past its step limit");

  a_md_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == ST_DIVX || state_q == ST_DIVY || state_q == ST_MULX
      || state_q == ST_MULY || state_q == ST_DIVE || state_q == ST_MULP))
    else $error("multiply/divide finished outside an arithmetic state");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!m_valid_q || m_tready_i)) |=>
      (m_valid_q && state_q == ST_IDLE))
    else $error("result word not loaded");

endmodule

`default_nettype wire
